// ===== design/spt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the spawn pressure throttle
// Field widths, transaction payload structs, codes and threshold constants.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int USAGE_W         = 23;
    localparam int ID_WIDTH        = 16;
    localparam int TIMER_W         = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 23;
    localparam int QUEUE_DEPTH_DEF = 16;

    // light = limit/10*9, heavy = limit/16*15
    localparam int LIGHT_DIV   = 10;
    localparam int LIGHT_MUL   = 9;
    localparam int HEAVY_SHIFT = 4;
    localparam int DIV10_SHIFT = 26;
    localparam int Q_W         = 20;
    localparam logic [USAGE_W-1:0] DIV10_RECIP =
        USAGE_W'(((64'd1 << DIV10_SHIFT) + LIGHT_DIV - 1) / LIGHT_DIV);

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SPAWN  = 2'd1,
        REQ_ALARM  = 2'd2,
        REQ_CANCEL = 2'd3
    } req_e;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_FORWARD = 2'd1,
        ACT_HOLD    = 2'd2,
        ACT_DROP    = 2'd3
    } act_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PID_LIMIT    = 3'd0,
        CFG_CHECK_IVL    = 3'd1,
        CFG_REPEAT_IVL   = 3'd2,
        CFG_FIRST_RETRY  = 3'd3,
        CFG_BUSY_RETRY   = 3'd4,
        CFG_DRAIN_RETRY  = 3'd5
    } cfg_e;

    typedef struct packed {
        req_e                req_type;
        logic [USAGE_W-1:0]  usage;
        logic [ID_WIDTH-1:0] request_id;
    } in_t;

    typedef struct packed {
        act_e                action;
        logic [ID_WIDTH-1:0] forwarded_id;
        logic                pressure_warning;
        logic [USAGE_W-1:0]  reported_usage;
    } out_t;

    typedef struct packed {
        logic               busy;
        logic [USAGE_W-1:0] light;
        logic [USAGE_W-1:0] heavy;
    } thr_t;

endpackage
`default_nettype wire

// ===== design/spt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/spt_thresh.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spt_thresh: pressure threshold unit
// Derives light (limit/10*9) in two registered stages and heavy (limit/16*15)
// in heavy_reg; busy while a new limit propagates.
// ----------------------------------------------------------------------------
module spt_thresh
    import spt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [USAGE_W-1:0] pid_limit,
    input  wire logic               load,
    output thr_t                    thr
);

    logic [2*USAGE_W-1:0] prod;
    logic [Q_W-1:0]       q_reg;
    logic [USAGE_W:0]     qx10;
    logic [USAGE_W:0]     rem;
    logic [Q_W-1:0]       q_fix;
    logic [USAGE_W-1:0]   light_reg;
    logic [USAGE_W-1:0]   heavy_reg;
    logic [USAGE_W-HEAVY_SHIFT-1:0] h16;
    logic [1:0]           wait_reg;

    assign prod  = (2*USAGE_W)'(pid_limit) * (2*USAGE_W)'(DIV10_RECIP);
    assign qx10  = (USAGE_W+1)'({q_reg, 3'b000}) + (USAGE_W+1)'({q_reg, 1'b0});
    assign rem   = (USAGE_W+1)'(pid_limit) - qx10;
    assign q_fix = (rem >= (USAGE_W+1)'(LIGHT_DIV)) ? q_reg + 1'b1 : q_reg;
    assign h16   = pid_limit[USAGE_W-1:HEAVY_SHIFT];

    always_ff @(posedge aclk) begin
        q_reg     <= prod[DIV10_SHIFT +: Q_W];
        light_reg <= USAGE_W'({q_fix, 3'b000}) + USAGE_W'(q_fix);
        heavy_reg <= USAGE_W'({h16, 4'b0000}) - USAGE_W'(h16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg <= 2'd2;
        end else if (load) begin
            wait_reg <= 2'd2;
        end else if (wait_reg != 2'd0) begin
            wait_reg <= wait_reg - 2'd1;
        end
    end

    assign thr.busy  = (wait_reg != 2'd0);
    assign thr.light = light_reg;
    assign thr.heavy = heavy_reg;

endmodule
`default_nettype wire

// ===== design/spawn_pressure_throttle_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spawn_pressure_throttle_core: admission throttle for spawn requests
// Ticks drive repeat and retry timers; heavy-pressure spawns with a timer
// pending are held in a RAM-backed FIFO, released one at a time on retry.
//
//   channel   ports                            direction
//   s_        s_valid s_ready s_payload        in  (in_t transaction)
//   m_        m_valid m_ready m_payload        out (out_t transaction)
//   cfg_      cfg_valid cfg_ready cfg_index    in  (register write)
//             cfg_data
//
// One transaction in flight. Tick, request and alarm go through ST_EXEC and
// ST_FINISH to the result. Cancel reads one held entry from the id RAM per
// cycle. A releasing tick also runs ST_DROP_A and, unless heavy, ST_POP
// and ST_DROP_B, skipping cancelled heads. After reset and after each
// pid_limit write, s_ready stays low while the thresholds settle. While m_
// stalls, the next s_ transaction is accepted; it then waits in ST_FINISH.
// ----------------------------------------------------------------------------
module spawn_pressure_throttle_core
    import spt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_payload,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_payload,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DROP_A,
        ST_POP,
        ST_DROP_B,
        ST_CANCEL,
        ST_FINISH
    } state_e;

    // configuration
    logic [USAGE_W-1:0] pid_limit_reg;
    logic [TIMER_W-1:0] check_ivl_reg;
    logic [TIMER_W-1:0] repeat_ivl_reg;
    logic [TIMER_W-1:0] first_retry_reg;
    logic [TIMER_W-1:0] busy_retry_reg;
    logic [TIMER_W-1:0] drain_retry_reg;
    logic               thr_load;
    thr_t               thr;

    // control state
    state_e             state_reg, state_next;
    in_t                item_reg, item_next;
    out_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_payload_reg, m_payload_next;
    logic               rep_p_reg, rep_p_next;
    logic [TIMER_W-1:0] rep_rem_reg, rep_rem_next;
    logic               ret_p_reg, ret_p_next;
    logic [TIMER_W-1:0] ret_rem_reg, ret_rem_next;
    logic [TIMER_W-1:0] tsc_reg, tsc_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   cidx_reg, cidx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_slot_reg, cmp_slot_next;

    // id RAM
    logic                ram_we;
    logic [IDX_W-1:0]    tail_slot;
    logic [IDX_W-1:0]    cancel_slot;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ID_WIDTH-1:0] ram_rdata;

    logic [TIMER_W-1:0] rep_dec;
    logic [TIMER_W-1:0] ret_dec;
    logic               light_hit;
    logic               heavy_hit;
    logic               full;

    function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign thr_load  = cfg_valid && (cfg_index == CFG_PID_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pid_limit_reg   <= USAGE_W'(4096);
            check_ivl_reg   <= TIMER_W'(1000);
            repeat_ivl_reg  <= TIMER_W'(2000);
            first_retry_reg <= TIMER_W'(250);
            busy_retry_reg  <= TIMER_W'(100);
            drain_retry_reg <= TIMER_W'(20);
        end else if (cfg_valid) begin
            unique case (cfg_e'(cfg_index))
                CFG_PID_LIMIT:   pid_limit_reg   <= cfg_data[USAGE_W-1:0];
                CFG_CHECK_IVL:   check_ivl_reg   <= cfg_data[TIMER_W-1:0];
                CFG_REPEAT_IVL:  repeat_ivl_reg  <= cfg_data[TIMER_W-1:0];
                CFG_FIRST_RETRY: first_retry_reg <= cfg_data[TIMER_W-1:0];
                CFG_BUSY_RETRY:  busy_retry_reg  <= cfg_data[TIMER_W-1:0];
                CFG_DRAIN_RETRY: drain_retry_reg <= cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    spt_thresh u_thresh (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pid_limit (pid_limit_reg),
        .load      (thr_load),
        .thr       (thr)
    );

    spt_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ids (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_slot),
        .wdata (item_reg.request_id),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign tail_slot   = wrap_slot(head_reg, count_reg);
    assign cancel_slot = wrap_slot(head_reg, cidx_reg);
    assign ram_raddr   = (state_reg == ST_CANCEL) ? cancel_slot : head_reg;

    assign rep_dec   = (rep_rem_reg != '0) ? rep_rem_reg - 1'b1 : rep_rem_reg;
    assign ret_dec   = (ret_rem_reg != '0) ? ret_rem_reg - 1'b1 : ret_rem_reg;
    assign light_hit = (item_reg.usage != '0) && (item_reg.usage >= thr.light);
    assign heavy_hit = (item_reg.usage != '0) && (item_reg.usage >= thr.heavy);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign s_ready   = (state_reg == ST_IDLE) && !thr.busy;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        rep_p_next     = rep_p_reg;
        rep_rem_next   = rep_rem_reg;
        ret_p_next     = ret_p_reg;
        ret_rem_next   = ret_rem_reg;
        tsc_next       = tsc_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        cidx_next      = cidx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_slot_next  = cmp_slot_reg;
        ram_we         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next  = s_payload;
                    res_next   = '0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_FINISH;
                unique case (item_reg.req_type)
                    REQ_TICK: begin
                        if (tsc_reg != '1) begin
                            tsc_next = tsc_reg + 1'b1;
                        end
                        if (rep_p_reg) begin
                            rep_rem_next = rep_dec;
                            if (rep_dec == '0) begin
                                rep_p_next = 1'b0;
                                tsc_next   = '0;
                                if (light_hit) begin
                                    res_next.pressure_warning = 1'b1;
                                    res_next.reported_usage   = item_reg.usage;
                                    rep_p_next   = 1'b1;
                                    rep_rem_next = repeat_ivl_reg;
                                end
                            end
                        end
                        if (ret_p_reg) begin
                            ret_rem_next = ret_dec;
                            if (ret_dec == '0) begin
                                ret_p_next = 1'b0;
                                state_next = ST_DROP_A;
                            end
                        end
                    end
                    REQ_SPAWN: begin
                        if (!rep_p_reg && !ret_p_reg) begin
                            if (tsc_reg >= check_ivl_reg) begin
                                tsc_next = '0;
                                if (light_hit) begin
                                    res_next.pressure_warning = 1'b1;
                                    res_next.reported_usage   = item_reg.usage;
                                    rep_p_next   = 1'b1;
                                    rep_rem_next = repeat_ivl_reg;
                                end
                            end
                            res_next.action       = ACT_FORWARD;
                            res_next.forwarded_id = item_reg.request_id;
                        end else if (!heavy_hit) begin
                            res_next.action       = ACT_FORWARD;
                            res_next.forwarded_id = item_reg.request_id;
                        end else if (full) begin
                            res_next.action = ACT_DROP;
                        end else begin
                            ram_we                = 1'b1;
                            valid_next[tail_slot] = 1'b1;
                            count_next            = count_reg + 1'b1;
                            res_next.action       = ACT_HOLD;
                            if (!ret_p_reg || (ret_rem_reg > first_retry_reg)) begin
                                ret_p_next   = 1'b1;
                                ret_rem_next = first_retry_reg;
                            end
                        end
                    end
                    REQ_ALARM: begin
                        tsc_next = '0;
                        if (item_reg.usage >= thr.light) begin
                            res_next.pressure_warning = 1'b1;
                            res_next.reported_usage   = item_reg.usage;
                            if (!rep_p_reg || (rep_rem_reg > repeat_ivl_reg)) begin
                                rep_p_next   = 1'b1;
                                rep_rem_next = repeat_ivl_reg;
                            end
                        end
                    end
                    REQ_CANCEL: begin
                        cidx_next    = '0;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_CANCEL;
                    end
                    default: ;
                endcase
            end

            ST_DROP_A: begin
                if ((count_reg != '0) && !valid_reg[head_reg]) begin
                    head_next  = next_idx(head_reg);
                    count_next = count_reg - 1'b1;
                end else if (count_reg == '0) begin
                    state_next = ST_FINISH;
                end else if (heavy_hit) begin
                    ret_p_next   = 1'b1;
                    ret_rem_next = busy_retry_reg;
                    state_next   = ST_FINISH;
                end else begin
                    state_next = ST_POP;
                end
            end

            ST_POP: begin
                res_next.action       = ACT_FORWARD;
                res_next.forwarded_id = ram_rdata;
                valid_next[head_reg]  = 1'b0;
                head_next             = next_idx(head_reg);
                count_next            = count_reg - 1'b1;
                state_next            = ST_DROP_B;
            end

            ST_DROP_B: begin
                if ((count_reg != '0) && !valid_reg[head_reg]) begin
                    head_next  = next_idx(head_reg);
                    count_next = count_reg - 1'b1;
                end else begin
                    if (count_reg != '0) begin
                        ret_p_next   = 1'b1;
                        ret_rem_next = drain_retry_reg;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_CANCEL: begin
                if (cmp_vld_reg && valid_reg[cmp_slot_reg] &&
                    (ram_rdata == item_reg.request_id)) begin
                    valid_next[cmp_slot_reg] = 1'b0;
                    state_next               = ST_FINISH;
                end else if (cidx_reg < count_reg) begin
                    cmp_vld_next  = 1'b1;
                    cmp_slot_next = cancel_slot;
                    cidx_next     = cidx_reg + 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_payload_next = res_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rep_p_reg   <= 1'b0;
            rep_rem_reg <= '0;
            ret_p_reg   <= 1'b0;
            ret_rem_reg <= '0;
            tsc_reg     <= '1;
            valid_reg   <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            cidx_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rep_p_reg   <= rep_p_next;
            rep_rem_reg <= rep_rem_next;
            ret_p_reg   <= ret_p_next;
            ret_rem_reg <= ret_rem_next;
            tsc_reg     <= tsc_next;
            valid_reg   <= valid_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            cidx_reg    <= cidx_next;
            cmp_vld_reg <= cmp_vld_next;
        end
        item_reg      <= item_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
        cmp_slot_reg  <= cmp_slot_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("held queue count exceeds depth");

    a_retry_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        ret_p_reg |-> (count_reg != '0))
        else $error("retry timer pending with empty queue");

    a_accept_starts_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not dispatched");

    a_settle_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(thr_load) |-> !s_ready)
        else $error("input accepted while thresholds settle");
`endif

endmodule
`default_nettype wire
